// ----- rtl/adcrm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcrm_pkg
// Types and constants shared by the ADC register model.
// ----------------------------------------------------------------------------
package adcrm_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 10;
  localparam int unsigned WordW   = 16;
  localparam int unsigned ChanW   = 5;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  typedef enum logic [OpW-1:0] {
    OP_WR_MUX   = 3'd0,
    OP_WR_CTL   = 3'd1,
    OP_RD_CTL   = 3'd2,
    OP_RD_WORD  = 3'd3,
    OP_RD_HIGH  = 3'd4,
    OP_RD_LOW   = 3'd5,
    OP_POLL     = 3'd6,
    OP_SOFT_RST = 3'd7
  } op_e;

  // control register bits
  localparam int unsigned CtlEnable  = 7;
  localparam int unsigned CtlStart   = 6;
  localparam int unsigned CtlFreeRun = 5;
  localparam int unsigned CtlDone    = 4;
  localparam int unsigned CtlIrqEn   = 3;

  // mux register bits
  localparam int unsigned MuxLeftAdj = 5;
  localparam logic [ChanW-1:0] PotChannel = 5'd5;

  typedef struct packed {
    logic [OpW-1:0]     opcode;
    logic [ByteW-1:0]   write_value;
    logic [SampleW-1:0] pot_sample;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] read_value;
    logic             irq_pulse;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/adc_register_model_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adc_register_model_top
// ADC register model with stream input and output.
// ----------------------------------------------------------------------------
// One item (bus access or poll tick) is taken per cycle and each gives one
// result item. The path is an input register, then the register update and
// read logic, then the result register. Throughput is one item a cycle, set
// by the single register stage that holds mux, control and result word;
// stalls on the output only stop input once both stages are full.
module adc_register_model_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [7:0] write_value, [17:8] pot_sample, [23:18] zero
  input  wire logic [adcrm_pkg::InDataW-1:0]   s_axis_tdata_i,
  // [2:0] opcode
  input  wire logic [adcrm_pkg::OpW-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [15:0] read_value
  output logic [adcrm_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // [0] irq_pulse
  output logic [0:0]                           m_axis_tuser_o
);
  import adcrm_pkg::*;

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  result_t res;
  logic    out_free;
  logic    fire;

  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign fire            = in_valid_q & out_free;
  assign s_axis_tready_o = ~in_valid_q | out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q.opcode      <= s_axis_tuser_i;
      in_item_q.write_value <= s_axis_tdata_i[7:0];
      in_item_q.pot_sample  <= s_axis_tdata_i[17:8];
    end
  end

  adcrm_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (in_item_q),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q.read_value;
  assign m_axis_tuser_o  = out_res_q.irq_pulse;

endmodule
`default_nettype wire

// ----- rtl/adcrm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// adcrm_regs
// Mux, control and result registers with the conversion and access logic.
// ----------------------------------------------------------------------------
module adcrm_regs (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire adcrm_pkg::item_t  item_i,
  output adcrm_pkg::result_t     result_o
);
  import adcrm_pkg::*;

  logic [ByteW-1:0] mux_q, mux_d;
  logic [ByteW-1:0] ctl_q, ctl_d;
  logic [WordW-1:0] word_q, word_d;

  logic [SampleW-1:0] conv_val;
  logic [WordW-1:0]   conv_word;
  logic [ByteW-1:0]   conv_ctl;
  logic               sync_conv;
  logic               poll_conv;
  logic [WordW-1:0]   rd_val;
  logic               irq;

  assign conv_val  = (mux_q[ChanW-1:0] == PotChannel) ? item_i.pot_sample : '0;
  assign conv_word = mux_q[MuxLeftAdj] ? {conv_val, 6'b0} : {6'b0, conv_val};

  always_comb begin
    conv_ctl = ctl_q;
    if (!ctl_q[CtlFreeRun]) begin
      conv_ctl[CtlStart] = 1'b0;
    end
    conv_ctl[CtlDone] = 1'b1;
  end

  assign sync_conv = ctl_q[CtlEnable] & ctl_q[CtlStart] & ~ctl_q[CtlIrqEn];
  assign poll_conv = ctl_q[CtlEnable] & ctl_q[CtlStart] & ctl_q[CtlIrqEn];

  always_comb begin
    mux_d  = mux_q;
    ctl_d  = ctl_q;
    word_d = word_q;
    irq    = 1'b0;
    case (op_e'(item_i.opcode))
      OP_WR_MUX: mux_d = item_i.write_value;
      OP_WR_CTL: ctl_d = item_i.write_value;
      OP_RD_CTL, OP_RD_WORD, OP_RD_HIGH, OP_RD_LOW: begin
        if (sync_conv) begin
          ctl_d  = conv_ctl;
          word_d = conv_word;
        end
      end
      OP_POLL: begin
        if (poll_conv) begin
          ctl_d          = conv_ctl;
          ctl_d[CtlDone] = 1'b0;
          word_d         = conv_word;
          irq            = 1'b1;
        end
      end
      default: begin
        mux_d  = '0;
        ctl_d  = '0;
        word_d = '0;
      end
    endcase
  end

  always_comb begin
    case (op_e'(item_i.opcode))
      OP_RD_CTL:  rd_val = {8'b0, ctl_d};
      OP_RD_WORD: rd_val = word_d;
      OP_RD_HIGH: rd_val = {8'b0, word_d[15:8]};
      OP_RD_LOW:  rd_val = {8'b0, word_d[7:0]};
      default:    rd_val = '0;
    endcase
  end

  assign result_o.read_value = rd_val;
  assign result_o.irq_pulse  = irq;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mux_q  <= '0;
      ctl_q  <= '0;
      word_q <= '0;
    end else if (fire_i) begin
      mux_q  <= mux_d;
      ctl_q  <= ctl_d;
      word_q <= word_d;
    end
  end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ADC register model. Bus accesses and poll ticks
// go in through the input stream; a local model of the mux, control and
// result registers predicts each result, which is checked against the output
// stream in order. Both sides idle at random in alternating stretches.
// ----------------------------------------------------------------------------
module tb_top;
  import adcrm_pkg::*;

  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandItems   = 1200;

  typedef struct {
    item_t acc;
    bit    drain;
  } pending_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic [OpW-1:0]      s_axis_tuser_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;

  pending_t    access_q[$];
  result_t     expected_q[$];

  logic [ByteW-1:0] mux_q   = '0;
  logic [ByteW-1:0] ctl_q   = '0;
  logic [WordW-1:0] word_q  = '0;

  logic        in_taken  = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned sent_cnt   = 0;
  int unsigned res_cnt    = 0;
  int unsigned cycle_cnt  = 0;
  int unsigned err_cnt    = 0;
  int unsigned item_cnt   = 0;

  adc_register_model_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #(ClkPeriod / 2.0) clk_i = ~clk_i;
  end

  // ---- register model ------------------------------------------------------

  function automatic void run_conversion(logic [SampleW-1:0] sample);
    logic [WordW-1:0] conv;
    conv = (mux_q[ChanW-1:0] == PotChannel) ? {{(WordW-SampleW){1'b0}}, sample} : '0;
    if (mux_q[MuxLeftAdj]) conv = conv << (WordW - SampleW);
    word_q = conv;
    if (!ctl_q[CtlFreeRun]) ctl_q[CtlStart] = 1'b0;
    ctl_q[CtlDone] = 1'b1;
  endfunction

  function automatic void sync_before_read(logic [SampleW-1:0] sample);
    if (ctl_q[CtlEnable] && ctl_q[CtlStart] && !ctl_q[CtlIrqEn]) run_conversion(sample);
  endfunction

  function automatic result_t predict_access(item_t acc);
    result_t res;
    res = '0;
    case (op_e'(acc.opcode))
      OP_WR_MUX: mux_q = acc.write_value;
      OP_WR_CTL: ctl_q = acc.write_value;
      OP_RD_CTL: begin
        sync_before_read(acc.pot_sample);
        res.read_value = {8'h00, ctl_q};
      end
      OP_RD_WORD: begin
        sync_before_read(acc.pot_sample);
        res.read_value = word_q;
      end
      OP_RD_HIGH: begin
        sync_before_read(acc.pot_sample);
        res.read_value = {8'h00, word_q[15:8]};
      end
      OP_RD_LOW: begin
        sync_before_read(acc.pot_sample);
        res.read_value = {8'h00, word_q[7:0]};
      end
      OP_POLL: begin
        if (ctl_q[CtlEnable] && ctl_q[CtlStart] && ctl_q[CtlIrqEn]) begin
          run_conversion(acc.pot_sample);
          ctl_q[CtlDone] = 1'b0;
          res.irq_pulse  = 1'b1;
        end
      end
      default: begin
        mux_q  = '0;
        ctl_q  = '0;
        word_q = '0;
      end
    endcase
    return res;
  endfunction

  // ---- stimulus helpers ----------------------------------------------------

  task automatic add_access(op_e op, logic [ByteW-1:0] wv, logic [SampleW-1:0] pot);
    pending_t p;
    p.acc.opcode      = op;
    p.acc.write_value = wv;
    p.acc.pot_sample  = pot;
    p.drain           = 1'b0;
    access_q.push_back(p);
    item_cnt++;
  endtask

  task automatic add_drain();
    pending_t p;
    p.acc   = '0;
    p.drain = 1'b1;
    access_q.push_back(p);
  endtask

  function automatic logic [SampleW-1:0] draw_pot();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SampleW'($urandom_range(0, 1023));
    endcase
  endfunction

  // ---- driver --------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (s_axis_tvalid_i && !in_taken) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      gap_left--;
      s_axis_tvalid_i <= 1'b0;
    end else if (access_q.size() != 0 && access_q[0].drain) begin
      s_axis_tvalid_i <= 1'b0;
      if (expected_q.size() == 0) void'(access_q.pop_front());
    end else if (access_q.size() != 0) begin
      s_axis_tdata_i  <= {{(InDataW-ByteW-SampleW){1'b0}},
                          access_q[0].acc.pot_sample, access_q[0].acc.write_value};
      s_axis_tuser_i  <= access_q[0].acc.opcode;
      s_axis_tvalid_i <= 1'b1;
      void'(access_q.pop_front());
      gap_left = sent_cnt[7] ? $urandom_range(0, 4) : 0;
      sent_cnt++;
    end else begin
      s_axis_tvalid_i <= 1'b0;
    end
  end

  // ---- sink ----------------------------------------------------------------

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (out_taken) stall_left = res_cnt[6] ? 0 : $urandom_range(0, 4);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---- monitor and checker -------------------------------------------------

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("[adc_register_model_top] ERROR");
      $finish;
    end else if (rst_ni) begin
      in_taken  <= s_axis_tvalid_i && s_axis_tready_o;
      out_taken <= m_axis_tvalid_o && m_axis_tready_i;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        res_cnt++;
        if (expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result read_value %h irq %b", $time,
                   m_axis_tdata_o, m_axis_tuser_o[0]);
        end else begin
          if (m_axis_tdata_o !== expected_q[0].read_value) begin
            err_cnt++;
            $display("%0t: read_value expected %h actual %h", $time,
                     expected_q[0].read_value, m_axis_tdata_o);
          end
          if (m_axis_tuser_o[0] !== expected_q[0].irq_pulse) begin
            err_cnt++;
            $display("%0t: irq_pulse expected %b actual %b", $time,
                     expected_q[0].irq_pulse, m_axis_tuser_o[0]);
          end
          void'(expected_q.pop_front());
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o)
        expected_q.push_back(predict_access(item_t'({s_axis_tuser_i,
                                                     s_axis_tdata_i[ByteW-1:0],
                                                     s_axis_tdata_i[ByteW+SampleW-1:ByteW]})));
    end
  end

  // ---- sequence ------------------------------------------------------------

  initial begin
    int unsigned sel;
    int unsigned reads;
    logic [ChanW-1:0] chan;
    logic [ByteW-1:0] ctl;

    // reset values, then plain conversion on the pot channel
    add_access(OP_RD_CTL,  8'h00, 10'h000);
    add_access(OP_RD_WORD, 8'h00, 10'h3FF);
    add_access(OP_WR_MUX,  8'h05, 10'h000);
    add_access(OP_WR_CTL,  8'hC0, 10'h000);
    add_access(OP_RD_WORD, 8'h00, 10'h3FF);
    add_access(OP_RD_CTL,  8'h00, 10'h000);
    // left-adjusted, free-running
    add_access(OP_WR_MUX,  8'h25, 10'h000);
    add_access(OP_WR_CTL,  8'hE0, 10'h000);
    add_access(OP_RD_HIGH, 8'h00, 10'h3FF);
    add_access(OP_RD_LOW,  8'h00, 10'h000);
    add_access(OP_RD_CTL,  8'h00, 10'h2AA);
    // channel other than the pot gives zero
    add_access(OP_WR_MUX,  8'h1F, 10'h000);
    add_access(OP_WR_CTL,  8'hC0, 10'h000);
    add_access(OP_RD_WORD, 8'h00, 10'h155);
    // interrupts on: read keeps stored value, poll converts
    add_access(OP_WR_MUX,  8'h05, 10'h000);
    add_access(OP_WR_CTL,  8'hC8, 10'h000);
    add_access(OP_RD_WORD, 8'h00, 10'h3FF);
    add_access(OP_POLL,    8'h00, 10'h2AA);
    add_access(OP_RD_CTL,  8'h00, 10'h000);
    add_access(OP_POLL,    8'h00, 10'h3FF);
    add_access(OP_WR_CTL,  8'hE8, 10'h000);
    add_access(OP_POLL,    8'hFF, 10'h3FF);
    add_access(OP_POLL,    8'h00, 10'h001);
    // all ones, then soft reset
    add_access(OP_WR_MUX,  8'hFF, 10'h3FF);
    add_access(OP_WR_CTL,  8'hFF, 10'h3FF);
    add_access(OP_SOFT_RST, 8'hFF, 10'h3FF);
    add_access(OP_RD_CTL,  8'h00, 10'h3FF);
    add_drain();

    while (item_cnt < RandItems) begin
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
        if ($urandom_range(0, 1) == 0) begin
          chan = ($urandom_range(0, 3) == 0) ? ChanW'($urandom_range(0, 31)) : PotChannel;
          add_access(OP_WR_MUX, {2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), chan},
                     draw_pot());
        end
        ctl = ByteW'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) begin
          ctl[CtlEnable] = 1'b1;
          ctl[CtlStart]  = 1'b1;
        end
        add_access(OP_WR_CTL, ctl, draw_pot());
        reads = $urandom_range(1, 4);
        repeat (reads)
          add_access(op_e'($urandom_range(OP_RD_CTL, OP_POLL)),
                     ByteW'($urandom_range(0, 255)), draw_pot());
      end else if (sel < 9) begin
        add_access(op_e'($urandom_range(OP_WR_MUX, OP_POLL)),
                   ByteW'($urandom_range(0, 255)), draw_pot());
      end else begin
        add_access(OP_SOFT_RST, ByteW'($urandom_range(0, 255)), draw_pot());
      end
      if (item_cnt % 300 < 6) add_drain();
    end

    rst_ni = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (access_q.size() != 0 || s_axis_tvalid_i || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[adc_register_model_top] OK");
    end else begin
      $display("[adc_register_model_top] ERROR");
    end
    $finish;
  end

endmodule
